>>> hdl/ttam_pkg.sv
// Shared types and constants for the tensor transpose address map.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package ttam_pkg;

  localparam int MAX_RANK    = 4;
  localparam int OFFSET_BITS = 32;
  localparam int SIZE_BITS   = 16;
  localparam int AXIS_BITS   = 2;
  localparam int RANK_BITS   = 3;
  localparam int PERM_BITS   = AXIS_BITS * MAX_RANK;
  localparam int COUNT_BITS  = 2 * OFFSET_BITS;
  localparam int DIV_STEPS   = OFFSET_BITS;
  localparam int NUM_DIV     = MAX_RANK - 1;
  localparam int DIV_STAGES  = NUM_DIV * DIV_STEPS;
  localparam int IN_W        = ((OFFSET_BITS + 7) / 8) * 8;
  localparam int OUT_W       = ((OFFSET_BITS + 2 + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RANK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERM  = 3'd5;

  localparam logic [RANK_BITS-1:0] RANK_RESET = 3'd4;
  localparam logic [PERM_BITS-1:0] PERM_RESET = 8'd27;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_PERM  = 2'd2,
    ERR_OVF   = 2'd3
  } err_e;

  typedef struct packed {
    logic [RANK_BITS-1:0]                  rank;
    logic [MAX_RANK-1:0][SIZE_BITS-1:0]    size_in;
    logic [MAX_RANK-1:0][SIZE_BITS-1:0]    size_out;
    logic [MAX_RANK-1:0][AXIS_BITS-1:0]    perm;
    logic                                  perm_ok;
    logic                                  ovf;
    logic [COUNT_BITS-1:0]                 count;
  } cfg_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0]             off;
    logic [OFFSET_BITS-1:0]             w;
    logic [SIZE_BITS-1:0]               r;
    logic [MAX_RANK-1:0][SIZE_BITS-1:0] idx;
  } item_t;

endpackage

>>> hdl/ttam_cfg.sv
// Configuration registers and their decode: clamped rank, effective sizes,
// permutation check and element count. Depends on ttam_pkg.
`timescale 1ns / 1ps

module ttam_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ttam_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [ttam_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output ttam_pkg::cfg_t                      cfg_o
);

  logic [ttam_pkg::RANK_BITS-1:0]                           rank_q;
  logic [ttam_pkg::MAX_RANK-1:0][ttam_pkg::SIZE_BITS-1:0]   size_q;
  logic [ttam_pkg::PERM_BITS-1:0]                           perm_q;
  logic [ttam_pkg::RANK_BITS-1:0]                           rank_eff;
  logic [ttam_pkg::MAX_RANK-1:0][ttam_pkg::SIZE_BITS-1:0]   size_in;
  logic [ttam_pkg::MAX_RANK-1:0][ttam_pkg::SIZE_BITS-1:0]   size_out;
  logic [ttam_pkg::MAX_RANK-1:0][ttam_pkg::AXIS_BITS-1:0]   perm;
  logic                                                     perm_ok;
  logic [2*ttam_pkg::SIZE_BITS-1:0]                         p2_d, p2_q;
  logic [3*ttam_pkg::SIZE_BITS-1:0]                         p3_d, p3_q;
  logic [ttam_pkg::COUNT_BITS-1:0]                          p4_d, p4_q;
  logic                                                     ovf_d, ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= ttam_pkg::RANK_RESET;
      size_q <= {ttam_pkg::MAX_RANK{ttam_pkg::SIZE_BITS'(1)}};
      perm_q <= ttam_pkg::PERM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ttam_pkg::REG_RANK:  rank_q    <= cfg_data_i[ttam_pkg::RANK_BITS-1:0];
        ttam_pkg::REG_SIZE0: size_q[0] <= cfg_data_i[ttam_pkg::SIZE_BITS-1:0];
        ttam_pkg::REG_SIZE1: size_q[1] <= cfg_data_i[ttam_pkg::SIZE_BITS-1:0];
        ttam_pkg::REG_SIZE2: size_q[2] <= cfg_data_i[ttam_pkg::SIZE_BITS-1:0];
        ttam_pkg::REG_SIZE3: size_q[3] <= cfg_data_i[ttam_pkg::SIZE_BITS-1:0];
        ttam_pkg::REG_PERM:  perm_q    <= cfg_data_i[ttam_pkg::PERM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rank_q == '0) begin
      rank_eff = ttam_pkg::RANK_BITS'(1);
    end else if (rank_q > ttam_pkg::RANK_BITS'(ttam_pkg::MAX_RANK)) begin
      rank_eff = ttam_pkg::RANK_BITS'(ttam_pkg::MAX_RANK);
    end else begin
      rank_eff = rank_q;
    end
    perm_ok = 1'b1;
    for (int i = 0; i < ttam_pkg::MAX_RANK; i++) begin
      perm[i] = perm_q[ttam_pkg::AXIS_BITS*i +: ttam_pkg::AXIS_BITS];
      if (ttam_pkg::RANK_BITS'(i) < rank_eff) begin
        size_in[i]  = size_q[i];
        size_out[i] = size_q[perm[i]];
        if ({1'b0, perm[i]} >= rank_eff) begin
          perm_ok = 1'b0;
        end
        for (int j = 0; j < i; j++) begin
          if (perm[j] == perm[i]) begin
            perm_ok = 1'b0;
          end
        end
      end else begin
        size_in[i]  = ttam_pkg::SIZE_BITS'(1);
        size_out[i] = ttam_pkg::SIZE_BITS'(1);
      end
    end
  end

  assign p2_d  = (2*ttam_pkg::SIZE_BITS)'(size_in[0]) * (2*ttam_pkg::SIZE_BITS)'(size_in[1]);
  assign p3_d  = (3*ttam_pkg::SIZE_BITS)'(p2_q) * (3*ttam_pkg::SIZE_BITS)'(size_in[2]);
  assign p4_d  = ttam_pkg::COUNT_BITS'(p3_q) * ttam_pkg::COUNT_BITS'(size_in[3]);
  assign ovf_d = (|p3_q[3*ttam_pkg::SIZE_BITS-1:ttam_pkg::OFFSET_BITS])
               | (|p4_q[ttam_pkg::COUNT_BITS-1:ttam_pkg::OFFSET_BITS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_q  <= '0;
      p3_q  <= '0;
      p4_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      p2_q  <= p2_d;
      p3_q  <= p3_d;
      p4_q  <= p4_d;
      ovf_q <= ovf_d;
    end
  end

  assign cfg_o.rank     = rank_eff;
  assign cfg_o.size_in  = size_in;
  assign cfg_o.size_out = size_out;
  assign cfg_o.perm     = perm;
  assign cfg_o.perm_ok  = perm_ok;
  assign cfg_o.ovf      = ovf_q;
  assign cfg_o.count    = p4_q;

endmodule

>>> hdl/ttam_div_stage.sv
// One registered step of the restoring divider that splits the output offset
// into per-axis indices. Depends on ttam_pkg.
`timescale 1ns / 1ps

module ttam_div_stage (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              first_i,
  input  logic                              last_i,
  input  logic [ttam_pkg::AXIS_BITS-1:0]    axis_i,
  input  logic [ttam_pkg::SIZE_BITS-1:0]    divisor_i,
  input  logic                              valid_i,
  input  ttam_pkg::item_t                   item_i,
  output logic                              valid_o,
  output ttam_pkg::item_t                   item_o
);

  logic [ttam_pkg::SIZE_BITS-1:0] r_in;
  logic [ttam_pkg::SIZE_BITS:0]   t;
  logic                           ge;
  ttam_pkg::item_t                item_d, item_q;
  logic                           valid_q;

  always_comb begin
    item_d   = item_i;
    r_in     = first_i ? '0 : item_i.r;
    t        = {r_in, item_i.w[ttam_pkg::OFFSET_BITS-1]};
    ge       = t >= {1'b0, divisor_i};
    item_d.w = {item_i.w[ttam_pkg::OFFSET_BITS-2:0], ge};
    item_d.r = ge ? ttam_pkg::SIZE_BITS'(t - {1'b0, divisor_i}) : t[ttam_pkg::SIZE_BITS-1:0];
    if (last_i) begin
      item_d.idx[axis_i] = item_d.r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hdl/ttam_horner.sv
// Scatters output indices through the permutation, folds them into the input
// offset over three multiply stages, and selects the error code. Depends on ttam_pkg.
`timescale 1ns / 1ps

module ttam_horner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  ttam_pkg::cfg_t                    cfg_i,
  input  logic                              valid_i,
  input  ttam_pkg::item_t                   item_i,
  output logic                              valid_o,
  output logic [ttam_pkg::OFFSET_BITS-1:0]  source_offset_o,
  output ttam_pkg::err_e                    error_code_o
);

  logic [ttam_pkg::MAX_RANK-1:0][ttam_pkg::SIZE_BITS-1:0] idx_out, idx_in;
  logic [ttam_pkg::MAX_RANK-1:0][ttam_pkg::SIZE_BITS-1:0] in1_q, in2_q;
  logic [ttam_pkg::OFFSET_BITS-1:0] acc1_d, acc1_q, acc2_d, acc2_q, acc3_d, acc3_q;
  logic [ttam_pkg::OFFSET_BITS-1:0] off1_q, off2_q, off3_q;
  logic                             v1_q, v2_q, v3_q, vo_q;
  ttam_pkg::err_e                   err_d, err_q;
  logic [ttam_pkg::OFFSET_BITS-1:0] src_d, src_q;

  always_comb begin
    idx_out    = item_i.idx;
    idx_out[0] = item_i.w[ttam_pkg::SIZE_BITS-1:0];
    idx_in     = '0;
    for (int a = 0; a < ttam_pkg::MAX_RANK; a++) begin
      for (int i = 0; i < ttam_pkg::MAX_RANK; i++) begin
        if (ttam_pkg::RANK_BITS'(i) < cfg_i.rank &&
            cfg_i.perm[i] == ttam_pkg::AXIS_BITS'(a)) begin
          idx_in[a] = idx_in[a] | idx_out[i];
        end
      end
    end
  end

  assign acc1_d = ttam_pkg::OFFSET_BITS'(idx_in[0]) * ttam_pkg::OFFSET_BITS'(cfg_i.size_in[1])
                + ttam_pkg::OFFSET_BITS'(idx_in[1]);
  assign acc2_d = acc1_q * ttam_pkg::OFFSET_BITS'(cfg_i.size_in[2])
                + ttam_pkg::OFFSET_BITS'(in1_q[2]);
  assign acc3_d = acc2_q * ttam_pkg::OFFSET_BITS'(cfg_i.size_in[3])
                + ttam_pkg::OFFSET_BITS'(in2_q[3]);

  always_comb begin
    if (!cfg_i.perm_ok) begin
      err_d = ttam_pkg::ERR_PERM;
    end else if (cfg_i.ovf) begin
      err_d = ttam_pkg::ERR_OVF;
    end else if (ttam_pkg::COUNT_BITS'(off3_q) >= cfg_i.count) begin
      err_d = ttam_pkg::ERR_RANGE;
    end else begin
      err_d = ttam_pkg::ERR_NONE;
    end
    src_d = (err_d == ttam_pkg::ERR_NONE) ? acc3_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc1_q <= acc1_d;
      in1_q  <= idx_in;
      off1_q <= item_i.off;
      acc2_q <= acc2_d;
      in2_q  <= in1_q;
      off2_q <= off1_q;
      acc3_q <= acc3_d;
      off3_q <= off2_q;
      err_q  <= err_d;
      src_q  <= src_d;
    end
  end

  assign valid_o         = vo_q;
  assign source_offset_o = src_q;
  assign error_code_o    = err_q;

endmodule

>>> hdl/tensor_transpose_address_map.sv
// Top level of the tensor transpose address map: config block, divider chain
// and offset fold. Depends on ttam_pkg, ttam_cfg, ttam_div_stage and ttam_horner.
//
// Each item on the slave stream carries a flat row-major output offset; one
// item leaves the master stream per input item with the flat input offset
// to copy from and an error code (0 ok, 1 out of range, 2 bad permutation,
// 3 size overflow); the offset reads 0 on any error.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i: rank, four axis sizes and
// the packed permutation. The user must write them only while the stream is empty; the
// block itself does not enforce this. The pipeline holds 96 divider steps (32 per split
// axis) of the one-bit restoring divider, three multiply-add stages and the output register.
// Throughput is one item per cycle unless the receiver stalls; the divider chain is fully pipelined.
// Reset empties the pipeline and loads rank 4, unit sizes and reversed axes.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops
// while a result waits; nothing is lost or repeated.
`timescale 1ns / 1ps

module tensor_transpose_address_map (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ttam_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ttam_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ttam_pkg::IN_W-1:0]         s_axis_tdata,   // output_offset[31:0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ttam_pkg::OUT_W-1:0]        m_axis_tdata    // source_offset[31:0], error_code[33:32]
);

  ttam_pkg::cfg_t                   cfg;
  logic                             en;
  logic                             valid_pipe [0:ttam_pkg::DIV_STAGES];
  ttam_pkg::item_t                  item_pipe  [0:ttam_pkg::DIV_STAGES];
  logic [ttam_pkg::OFFSET_BITS-1:0] source_offset;
  ttam_pkg::err_e                   error_code;

  ttam_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    valid_pipe[0]    = s_axis_tvalid;
    item_pipe[0].off = s_axis_tdata;
    item_pipe[0].w   = s_axis_tdata;
    item_pipe[0].r   = '0;
    item_pipe[0].idx = '0;
  end

  for (genvar k = 0; k < ttam_pkg::DIV_STAGES; k++) begin : g_div
    localparam int AXIS = ttam_pkg::MAX_RANK - 1 - k / ttam_pkg::DIV_STEPS;
    ttam_div_stage u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .first_i   ((k % ttam_pkg::DIV_STEPS) == 0),
      .last_i    ((k % ttam_pkg::DIV_STEPS) == ttam_pkg::DIV_STEPS - 1),
      .axis_i    (ttam_pkg::AXIS_BITS'(AXIS)),
      .divisor_i (cfg.size_out[AXIS]),
      .valid_i   (valid_pipe[k]),
      .item_i    (item_pipe[k]),
      .valid_o   (valid_pipe[k+1]),
      .item_o    (item_pipe[k+1])
    );
  end

  ttam_horner u_horner (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .cfg_i           (cfg),
    .valid_i         (valid_pipe[ttam_pkg::DIV_STAGES]),
    .item_i          (item_pipe[ttam_pkg::DIV_STAGES]),
    .valid_o         (m_axis_tvalid),
    .source_offset_o (source_offset),
    .error_code_o    (error_code)
  );

  assign m_axis_tdata = {(ttam_pkg::OUT_W - ttam_pkg::OFFSET_BITS - 2)'(0),
                         error_code, source_offset};

  a_err_zero_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && error_code != ttam_pkg::ERR_NONE |-> source_offset == '0)
    else $error("error result with nonzero source offset");

  a_perm_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !cfg.perm_ok |-> error_code == ttam_pkg::ERR_PERM)
    else $error("bad permutation not reported");

  a_src_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && error_code == ttam_pkg::ERR_NONE
      |-> ttam_pkg::COUNT_BITS'(source_offset) < cfg.count)
    else $error("source offset beyond element count");

endmodule

>>> tb/sv/ttam_checker.sv
// Checker for the tensor transpose address map: watches both streams and the
// register port, predicts each result and compares. Depends on ttam_pkg.
`timescale 1ns / 1ps

module ttam_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ttam_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ttam_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [ttam_pkg::IN_W-1:0]         s_axis_tdata,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [ttam_pkg::OUT_W-1:0]        m_axis_tdata,
  output int                                fail_count_o,
  output int                                pending_o,
  output int                                result_count_o,
  output int                                err_seen_o [4]
);

  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] src;
  } addr_t;

  logic [2:0]  rank_q;
  logic [15:0] size_q [4];
  logic [7:0]  perm_q;
  addr_t       want_q [$];

  function automatic addr_t map_offset(input logic [31:0] off);
    addr_t       res;
    int unsigned r;
    int unsigned p [4];
    bit          used [4];
    longint unsigned cnt, o, d, src;
    longint unsigned idx_out [4];
    longint unsigned idx_in [4];
    res = '0;
    r = rank_q;
    if (r < 1) r = 1;
    if (r > ttam_pkg::MAX_RANK) r = ttam_pkg::MAX_RANK;
    for (int i = 0; i < 4; i++) used[i] = 0;
    for (int i = 0; i < r; i++) begin
      p[i] = (perm_q >> (2 * i)) & 3;
      if (p[i] >= r || used[p[i]]) begin
        res.code = ttam_pkg::ERR_PERM;
        return res;
      end
      used[p[i]] = 1;
    end
    cnt = 1;
    for (int i = 0; i < r; i++) begin
      cnt = cnt * size_q[i];
      if (cnt > 64'hFFFF_FFFF) begin
        res.code = ttam_pkg::ERR_OVF;
        return res;
      end
    end
    if (off >= cnt) begin
      res.code = ttam_pkg::ERR_RANGE;
      return res;
    end
    o = off;
    for (int i = r - 1; i >= 0; i--) begin
      d = size_q[p[i]];
      idx_out[i] = o % d;
      o = o / d;
    end
    for (int i = 0; i < r; i++) idx_in[p[i]] = idx_out[i];
    src = 0;
    for (int i = 0; i < r; i++) src = src * size_q[i] + idx_in[i];
    res.src  = src[31:0];
    res.code = ttam_pkg::ERR_NONE;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    addr_t w, got;
    if (!rst_ni) begin
      rank_q <= ttam_pkg::RANK_RESET;
      for (int i = 0; i < 4; i++) size_q[i] <= 16'd1;
      perm_q <= ttam_pkg::PERM_RESET;
      want_q.delete();
      fail_count_o   <= 0;
      result_count_o <= 0;
      for (int i = 0; i < 4; i++) err_seen_o[i] <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) want_q.push_back(map_offset(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[33:0];
        result_count_o <= result_count_o + 1;
        err_seen_o[got.code] <= err_seen_o[got.code] + 1;
        if (want_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10) $display("unexpected result: code %0d src %0h",
                                          got.code, got.src);
        end else begin
          w = want_q.pop_front();
          if (w.code != got.code || w.src != got.src || m_axis_tdata[39:34] != 0) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("mismatch: expected code %0d src %0h, got code %0d src %0h",
                       w.code, w.src, got.code, got.src);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ttam_pkg::REG_RANK:  rank_q <= cfg_data_i[2:0];
          ttam_pkg::REG_SIZE0: size_q[0] <= cfg_data_i;
          ttam_pkg::REG_SIZE1: size_q[1] <= cfg_data_i;
          ttam_pkg::REG_SIZE2: size_q[2] <= cfg_data_i;
          ttam_pkg::REG_SIZE3: size_q[3] <= cfg_data_i;
          ttam_pkg::REG_PERM:  perm_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  assign pending_o = want_q.size();
endmodule

>>> tb/sv/testbench.sv
// Stimulus and verdict for the tensor transpose address map: register
// settings, directed and random offsets, random stalls. Depends on ttam_pkg and ttam_checker.
`timescale 1ns / 1ps

module testbench;

  logic                            clk_i = 0;
  logic                            rst_ni = 0;
  logic                            cfg_we_i = 0;
  logic [ttam_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [ttam_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                            s_axis_tvalid = 0;
  logic                            s_axis_tready;
  logic [ttam_pkg::IN_W-1:0]       s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 0;
  logic [ttam_pkg::OUT_W-1:0]      m_axis_tdata;
  int                              fails, pending, results;
  int                              err_seen [4];
  bit                              hold_sink = 0;
  bit                              sink_on = 0;
  int                              settings_run = 0;
  logic [15:0]                     cur_size [4];
  int                              cur_rank;

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  tensor_transpose_address_map dut (.*);

  ttam_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fails), .pending_o(pending), .result_count_o(results),
    .err_seen_o(err_seen)
  );

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Receiver: random stalls, or a long hold-off when requested.
  always @(posedge clk_i) begin
    if (!sink_on || hold_sink) m_axis_tready <= 0;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic write_reg(input logic [ttam_pkg::CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we_i   <= 1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[15:0];
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (110) @(posedge clk_i);
  endtask

  task automatic setup(input int rk, input int s0, input int s1, input int s2,
                       input int s3, input int pm);
    drain();
    write_reg(ttam_pkg::REG_RANK, rk);
    write_reg(ttam_pkg::REG_SIZE0, s0);
    write_reg(ttam_pkg::REG_SIZE1, s1);
    write_reg(ttam_pkg::REG_SIZE2, s2);
    write_reg(ttam_pkg::REG_SIZE3, s3);
    write_reg(ttam_pkg::REG_PERM, pm);
    cur_size = '{s0[15:0], s1[15:0], s2[15:0], s3[15:0]};
    cur_rank = (rk == 0) ? 1 : (rk > 4 ? 4 : rk);
    settings_run++;
  endtask

  task automatic send(input logic [31:0] off);
    int g;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= off;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic idle_src();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_offset();
    longint unsigned cnt;
    cnt = 1;
    for (int i = 0; i < cur_rank; i++) cnt = cnt * cur_size[i];
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return (cnt > 0 && cnt <= 64'hFFFF_FFFF) ? cnt[31:0] : 32'hFFFF_FFFF;
      2: return (cnt > 0) ? 32'(cnt - 1) : 32'd0;
      default: return (cnt == 0) ? $urandom() :
                      (cnt > 64'hFFFF_FFFF ? $urandom() :
                       32'($urandom() % cnt[31:0]));
    endcase
  endfunction

  function automatic int rand_perm(input int rk);
    int a [4];
    int t, j, pm;
    a = '{0, 1, 2, 3};
    for (int i = rk - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = a[i]; a[i] = a[j]; a[j] = t;
    end
    pm = 0;
    for (int i = 0; i < 4; i++) pm |= ((i < rk) ? a[i] : $urandom_range(0, 3)) << (2 * i);
    return pm;
  endfunction

  function automatic int rand_size();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 65535);
      1: return 65535;
      2: return 1;
      default: return $urandom_range(1, 13);
    endcase
  endfunction

  initial begin
    #10000000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int rk, n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    sink_on <= 1;
    repeat (2) @(posedge clk_i);

    // Reset configuration: all unit sizes, reversed axes.
    send(0); send(1); send(32'hFFFF_FFFF);
    setup(4, 2, 3, 4, 5, 8'b00_01_10_11);
    for (int i = 0; i < 6; i++) send(i * 23);
    send(119); send(120);
    setup(0, 7, 1, 1, 1, 8'hFF);             // rank zero acts as one
    send(0); send(6); send(7);
    setup(7, 3, 3, 3, 3, 8'b01_00_10_11);    // rank above maximum acts as four
    send(80); send(81);
    setup(2, 4, 5, 9, 9, 8'b00_00_00_00);    // repeated axis
    send(0);
    setup(2, 4, 5, 9, 9, 8'b11_00_00_10);    // axis beyond rank
    send(0);
    setup(4, 65535, 65535, 2, 1, 8'b11_10_01_00); // too many elements
    send(5);
    setup(3, 5, 0, 5, 1, 8'b11_00_01_10);    // zero-size axis
    send(0); send(32'hFFFF_FFFF);
    setup(2, 65535, 65535, 1, 1, 8'b11_11_00_01);
    send(32'hFFFE_0000); send(32'hFFFE_0000); send(32'h8000_0000);

    // Long receiver hold-off so the pipeline fills and stalls the input.
    hold_sink = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_sink = 0;
      end
      for (int k = 0; k < 150; k++) send(rand_offset());
    join
    idle_src();

    n = 0;
    while (n < 1450) begin
      rk = $urandom_range(1, 4);
      if ($urandom_range(0, 7) == 0)
        setup($urandom_range(0, 7), rand_size(), rand_size(), rand_size(), rand_size(),
              $urandom_range(0, 255));
      else
        setup(rk, rand_size(), rand_size(), rand_size(), rand_size(), rand_perm(rk));
      for (int k = 0; k < 60; k++) begin
        send(rand_offset());
        n++;
      end
      idle_src();
      if ($urandom_range(0, 3) == 0) while (pending != 0) @(posedge clk_i);
    end

    idle_src();
    drain();
    $display("Ran %0d items over %0d register settings.", results, settings_run);
    $display("Codes seen: ok %0d, range %0d, perm %0d, overflow %0d.",
             err_seen[0], err_seen[1], err_seen[2], err_seen[3]);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

>>> filelist.f
hdl/ttam_pkg.sv
hdl/ttam_cfg.sv
hdl/ttam_div_stage.sv
hdl/ttam_horner.sv
hdl/tensor_transpose_address_map.sv
tb/sv/ttam_checker.sv
tb/sv/testbench.sv
